// ===== design/tftr_pkg.sv =====
package tftr_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned ColorW = 32;
  localparam int unsigned FmtW   = 3;

  localparam logic [FmtW-1:0] FMT_ARGB1555 = 3'd0;
  localparam logic [FmtW-1:0] FMT_RGB565   = 3'd1;
  localparam logic [FmtW-1:0] FMT_ARGB4444 = 3'd2;
  localparam logic [FmtW-1:0] FMT_YUV422   = 3'd3;

  typedef struct packed {
    logic [WordW-1:0] second_word;
    logic [WordW-1:0] first_word;
  } item_t;

  // status of the item held in the input register
  typedef struct packed {
    logic            valid;
    logic            phase;   // 1: second pixel of a YUV422 pair is next
    logic [FmtW-1:0] fmt;
  } stage_t;

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic              last;
  } result_t;

endpackage

// ===== design/texel_format_to_rgba8888.sv =====
// Texel word to RGBA8888 converter.
// Slave stream: tdata carries first_word in bits 15:0 and second_word in
// bits 31:16. Master stream: tdata is the packed pixel (alpha 31:24, blue,
// green, red 7:0) and tlast marks the final pixel of an input item.
// cfg_we_i/cfg_wdata_i write the pixel format; write it only while idle.
// Formats: ARGB1555, RGB565, ARGB4444 (also codes 4 to 7) give one pixel
// per item; YUV422 gives two pixels, the second with tlast set.
// Path: input register, conversion logic, result register.
// Throughput: one item per cycle for single-word formats while the receiver
// does not stall; a YUV422 item is held until both of its pixels have gone
// through the single result register feeding the output.
// The input register takes a new item in the same cycle that the last pixel
// of its current item moves to the result register, so both sides run at
// full rate together.
// Reset clears both registers to empty and the format to ARGB1555.
// When the receiver stalls the result register holds its pixel and the
// input register holds one more item; then tready drops.
module texel_format_to_rgba8888 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] first_word, [31:16] second_word
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] color
  output logic        m_axis_tlast_o
);

  tftr_pkg::item_t   in_item;
  tftr_pkg::item_t   item;
  tftr_pkg::stage_t  stage;
  tftr_pkg::result_t conv;
  tftr_pkg::result_t result;
  logic              take;

  assign in_item.first_word  = s_axis_tdata_i[15:0];
  assign in_item.second_word = s_axis_tdata_i[31:16];

  tftr_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .take_i      (take),
    .item_o      (item),
    .stage_o     (stage)
  );

  tftr_convert u_conv (
    .item_i   (item),
    .stage_i  (stage),
    .result_o (conv)
  );

  tftr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .result_i    (conv),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .result_o    (result)
  );

  assign m_axis_tdata_o = result.color;
  assign m_axis_tlast_o = result.last;

endmodule

// ===== design/tftr_in_stage.sv =====
module tftr_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tftr_pkg::item_t       in_item_i,
  input  logic                  take_i,
  output tftr_pkg::item_t       item_o,
  output tftr_pkg::stage_t      stage_o
);

  logic [tftr_pkg::FmtW-1:0] fmt_q;
  logic                      valid_q;
  logic                      phase_q;
  tftr_pkg::item_t           item_q;
  logic                      done;
  logic                      accept;

  // the item leaves once its final pixel moves to the result register
  assign done       = take_i && ((fmt_q != tftr_pkg::FMT_YUV422) || phase_q);
  assign in_ready_o = !valid_q || done;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= tftr_pkg::FMT_ARGB1555;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
      phase_q <= 1'b0;
    end else if (done) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (take_i) begin
      phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign item_o        = item_q;
  assign stage_o.valid = valid_q;
  assign stage_o.phase = phase_q;
  assign stage_o.fmt   = fmt_q;

endmodule

// ===== design/tftr_convert.sv =====
module tftr_convert (
  input  tftr_pkg::item_t   item_i,
  input  tftr_pkg::stage_t  stage_i,
  output tftr_pkg::result_t result_o
);

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    widen6 = {v, v[5:4]};
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] v);
    widen4 = {v, v};
  endfunction

  // value is scaled by 32: floor, then clamp to 0..255
  function automatic logic [7:0] clamp_scaled(input logic signed [15:0] s);
    logic [7:0] q;
    if (s[15]) begin
      q = 8'd0;
    end else if (|s[14:13]) begin
      q = 8'hFF;
    end else begin
      q = s[12:5];
    end
    clamp_scaled = q;
  endfunction

  logic [15:0]        w;
  logic [7:0]         y;
  logic signed [15:0] ys;
  logic signed [15:0] du;
  logic signed [15:0] dv;
  logic signed [15:0] r_s;
  logic signed [15:0] g_s;
  logic signed [15:0] b_s;
  logic [31:0]        yuv_color;
  logic               is_yuv;

  assign w      = item_i.first_word;
  assign is_yuv = (stage_i.fmt == tftr_pkg::FMT_YUV422);

  always_comb begin
    y   = stage_i.phase ? item_i.second_word[15:8] : item_i.first_word[15:8];
    ys  = $signed({3'd0, y, 5'd0});
    du  = $signed({8'd0, item_i.first_word[7:0]}) - 16'sd128;
    dv  = $signed({8'd0, item_i.second_word[7:0]}) - 16'sd128;
    r_s = ys + 16'sd44 * dv;
    g_s = ys - 16'sd11 * du - 16'sd22 * dv;
    b_s = ys + 16'sd55 * du;
    yuv_color = {8'hFF, clamp_scaled(b_s), clamp_scaled(g_s), clamp_scaled(r_s)};
  end

  always_comb begin
    case (stage_i.fmt)
      tftr_pkg::FMT_ARGB1555: begin
        result_o.color = {{8{w[15]}}, widen5(w[4:0]), widen5(w[9:5]), widen5(w[14:10])};
      end
      tftr_pkg::FMT_RGB565: begin
        result_o.color = {8'hFF, widen5(w[4:0]), widen6(w[10:5]), widen5(w[15:11])};
      end
      tftr_pkg::FMT_YUV422: begin
        result_o.color = yuv_color;
      end
      default: begin
        // ARGB4444 and the spare codes
        result_o.color = {widen4(w[15:12]), widen4(w[3:0]), widen4(w[7:4]),
                          widen4(w[11:8])};
      end
    endcase
    result_o.last = !is_yuv || stage_i.phase;
  end

endmodule

// ===== design/tftr_out_stage.sv =====
module tftr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tftr_pkg::stage_t  stage_i,
  input  tftr_pkg::result_t result_i,
  output logic              take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tftr_pkg::result_t result_o
);

  logic              valid_q;
  tftr_pkg::result_t result_q;

  assign take_o = stage_i.valid && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ===== design/tftr_checker.sv =====
module tftr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  // a stalled pixel holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  // only the first pixel of a YUV pair lacks tlast, and it is opaque
  a_first_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[31:24] == 8'hFF)
    else $error("non-last pixel is not opaque");

  // the second pixel of a pair follows right after the first is taken
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && m_axis_tlast_o)
    else $error("second pixel of pair did not follow");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

endmodule

bind texel_format_to_rgba8888 tftr_checker u_tftr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== tb/tb_texel_format_to_rgba8888.sv =====
module tb_texel_format_to_rgba8888;
  import tftr_pkg::*;

  // codes 4 to 7 decode as ARGB4444
  localparam logic [FmtW-1:0] FMT_4444_ALIAS4 = 3'd4;
  localparam logic [FmtW-1:0] FMT_4444_ALIAS5 = 3'd5;
  localparam logic [FmtW-1:0] FMT_4444_ALIAS6 = 3'd6;
  localparam logic [FmtW-1:0] FMT_4444_ALIAS7 = 3'd7;

  localparam int NumRows       = 22;
  localparam int NumPhases     = 12;
  localparam int PhaseItems    = 150;
  localparam int QuietPhase    = 4;
  localparam int PausePhase    = 8;
  localparam int HoldAfterPix  = 600;
  localparam int HoldCycles    = 300;
  localparam int StallLimit    = 2000;

  typedef struct packed {
    logic [FmtW-1:0]   fmt;
    logic [WordW-1:0]  w0;
    logic [WordW-1:0]  w1;
    logic              typed;
    logic [ColorW-1:0] color;
  } texel_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [15:0] first_word, [31:16] second_word
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [31:0] color
  logic        m_axis_tlast_o;

  result_t         pixel_q[$];
  logic [FmtW-1:0] fmt_now;
  int              errors;
  int              pixels_seen;
  int              idle_cycles;
  int              hold_left;
  bit              hold_done;
  bit              no_idle;

  texel_row_t texel_rows [NumRows] = '{
    '{FMT_ARGB1555,    16'h0000, 16'h0000, 1'b1, 32'h0000_0000},
    '{FMT_ARGB1555,    16'hFFFF, 16'h1234, 1'b1, 32'hFFFF_FFFF},
    '{FMT_ARGB1555,    16'h8000, 16'hFFFF, 1'b1, 32'hFF00_0000},
    '{FMT_ARGB1555,    16'h7FFF, 16'h0000, 1'b1, 32'h00FF_FFFF},
    '{FMT_RGB565,      16'h0000, 16'hFFFF, 1'b1, 32'hFF00_0000},
    '{FMT_RGB565,      16'hFFFF, 16'h0000, 1'b1, 32'hFFFF_FFFF},
    '{FMT_RGB565,      16'hF800, 16'h5A5A, 1'b1, 32'hFF00_00FF},
    '{FMT_RGB565,      16'h07E0, 16'hA5A5, 1'b1, 32'hFF00_FF00},
    '{FMT_ARGB4444,    16'h0000, 16'hFFFF, 1'b1, 32'h0000_0000},
    '{FMT_ARGB4444,    16'hFFFF, 16'h0000, 1'b1, 32'hFFFF_FFFF},
    '{FMT_ARGB4444,    16'h1234, 16'h0000, 1'b1, 32'h1144_3322},
    '{FMT_YUV422,      16'h0000, 16'h0000, 1'b0, 32'h0},
    '{FMT_YUV422,      16'hFFFF, 16'hFFFF, 1'b0, 32'h0},
    '{FMT_YUV422,      16'h8080, 16'h8080, 1'b0, 32'h0},
    '{FMT_YUV422,      16'h00FF, 16'hFF00, 1'b0, 32'h0},
    '{FMT_YUV422,      16'hFF00, 16'h00FF, 1'b0, 32'h0},
    '{FMT_YUV422,      16'h4000, 16'hC0FF, 1'b0, 32'h0},
    '{FMT_4444_ALIAS4, 16'hF0F0, 16'h0000, 1'b1, 32'hFF00_FF00},
    '{FMT_4444_ALIAS5, 16'h9C3E, 16'hFFFF, 1'b0, 32'h0},
    '{FMT_4444_ALIAS6, 16'h0F0F, 16'h0000, 1'b1, 32'h00FF_00FF},
    '{FMT_4444_ALIAS7, 16'h1234, 16'hFFFF, 1'b1, 32'h1144_3322},
    '{FMT_4444_ALIAS7, 16'hFFFF, 16'h0000, 1'b1, 32'hFFFF_FFFF}
  };

  logic [FmtW-1:0] fmt_plan [NumPhases] = '{
    FMT_YUV422, FMT_ARGB1555, FMT_RGB565, FMT_ARGB4444, FMT_YUV422, FMT_4444_ALIAS7,
    FMT_4444_ALIAS4, FMT_YUV422, FMT_4444_ALIAS5, FMT_4444_ALIAS6, FMT_ARGB1555, FMT_YUV422
  };

  texel_format_to_rgba8888 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // floor of a channel scaled by 32, clamped to a byte
  function automatic logic [7:0] clamp_channel(input int scaled);
    if (scaled < 0) return 8'd0;
    if ((scaled >>> 5) > 255) return 8'd255;
    return 8'(scaled >>> 5);
  endfunction

  function automatic logic [ColorW-1:0] yuv_color(input logic [7:0] luma, input int du,
                                                  input int dv);
    int ys;
    ys = int'(luma) * 32;
    return {8'hFF, clamp_channel(ys + 55 * du), clamp_channel(ys - 11 * du - 22 * dv),
            clamp_channel(ys + 44 * dv)};
  endfunction

  // queue the pixels that one texel item should produce under the current format
  function automatic void predict_pixels(input logic [WordW-1:0] w0, input logic [WordW-1:0] w1);
    logic [4:0]  r5, g5, b5;
    logic [5:0]  g6;
    logic [ColorW-1:0] color;
    int du, dv;
    if (fmt_now == FMT_YUV422) begin
      du = int'(w0[7:0]) - 128;
      dv = int'(w1[7:0]) - 128;
      pixel_q.push_back('{color: yuv_color(w0[15:8], du, dv), last: 1'b0});
      pixel_q.push_back('{color: yuv_color(w1[15:8], du, dv), last: 1'b1});
      return;
    end
    if (fmt_now == FMT_ARGB1555) begin
      r5 = w0[14:10]; g5 = w0[9:5]; b5 = w0[4:0];
      color = {{8{w0[15]}}, b5, b5[4:2], g5, g5[4:2], r5, r5[4:2]};
    end else if (fmt_now == FMT_RGB565) begin
      r5 = w0[15:11]; g6 = w0[10:5]; b5 = w0[4:0];
      color = {8'hFF, b5, b5[4:2], g6, g6[5:4], r5, r5[4:2]};
    end else begin
      color = {w0[15:12], w0[15:12], w0[3:0], w0[3:0], w0[7:4], w0[7:4], w0[11:8], w0[11:8]};
    end
    pixel_q.push_back('{color: color, last: 1'b1});
  endfunction

  // drop valid and hold until every queued pixel has come out
  task automatic drain_pixels();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_format(input logic [FmtW-1:0] fmt);
    drain_pixels();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = fmt;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    fmt_now  = fmt;
  endtask

  // offer one item after a random gap and hold it until taken
  task automatic send_texel(input logic [WordW-1:0] w0, input logic [WordW-1:0] w1,
                            input bit typed, input logic [ColorW-1:0] color);
    while (!no_idle && $urandom_range(99) < 27) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {w1, w0};
    do @(posedge clk_i); while (!(s_axis_tvalid_i && s_axis_tready_o));
    if (typed) pixel_q.push_back('{color: color, last: 1'b1});
    else predict_pixels(w0, w1);
  endtask

  // receiver: random stalls, one long hold-off once traffic is under way
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready_i = 1'b0;
        hold_left--;
      end else if (!hold_done && pixels_seen >= HoldAfterPix) begin
        hold_done       = 1'b1;
        hold_left       = HoldCycles - 1;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = no_idle || ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t exp_pix;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel: color %h last %b", m_axis_tdata_o, m_axis_tlast_o);
        errors++;
      end else begin
        exp_pix = pixel_q.pop_front();
        if (m_axis_tdata_o !== exp_pix.color) begin
          $error("color mismatch: expected %h, actual %h", exp_pix.color, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tlast_o !== exp_pix.last) begin
          $error("last mismatch: expected %b, actual %b", exp_pix.last, m_axis_tlast_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles > StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    errors          = 0;
    pixels_seen     = 0;
    idle_cycles     = 0;
    hold_left       = 0;
    hold_done       = 1'b0;
    no_idle         = 1'b0;
    fmt_now         = FMT_ARGB1555;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // first rows run on the reset format
    foreach (texel_rows[i]) begin
      if (texel_rows[i].fmt != fmt_now) set_format(texel_rows[i].fmt);
      send_texel(texel_rows[i].w0, texel_rows[i].w1, texel_rows[i].typed, texel_rows[i].color);
    end

    foreach (fmt_plan[p]) begin
      set_format(fmt_plan[p]);
      no_idle = (p == QuietPhase);
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == PausePhase && n == PhaseItems / 2) drain_pixels();
        send_texel(16'($urandom), 16'($urandom), 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    drain_pixels();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
